@@ rtl/core/efp_pkg.sv @@
// ----------------------------------------------------------------------------
// efp_pkg
// Shared types and constants of the event fragment parser.
// ----------------------------------------------------------------------------
package efp_pkg;

  localparam int unsigned WORD_W       = 16;
  localparam int unsigned POS_W        = 16;
  localparam int unsigned STATUS_POS_W = 17;
  localparam int unsigned START_W      = 15;
  localparam int unsigned LINK_W       = 5;
  localparam int unsigned LINK_COUNT   = 24;
  localparam int unsigned MASK_W       = 24;

  // event lengths above this are clamped
  localparam logic [POS_W-1:0]  MAX_EVENT_WORDS = 16'h8000;
  localparam logic [LINK_W-1:0] LAST_LINK       = LINK_W'(LINK_COUNT - 1);

  // result queue
  localparam int unsigned RESQ_DEPTH = 4;
  localparam int unsigned RESQ_AW    = $clog2(RESQ_DEPTH);
  localparam int unsigned RESQ_CW    = $clog2(RESQ_DEPTH + 1);

  typedef enum logic [1:0] {
    REC_FRAGMENT = 2'd0,
    REC_SUMMARY  = 2'd1,
    REC_ERROR    = 2'd2
  } rec_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_LINK_RANGE  = 2'd1,
    ERR_LINK_REPEAT = 2'd2
  } err_code_t;

  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic [POS_W-1:0]  event_length;
    logic              start_of_event;
  } item_t;

  typedef struct packed {
    rec_kind_t          kind;
    logic [LINK_W-1:0]  link;
    logic [WORD_W-1:0]  frag_length;
    logic [START_W-1:0] frag_start;
    logic [WORD_W-1:0]  frag_status;
    logic [WORD_W-1:0]  event_number;
    logic [WORD_W-1:0]  event_status;
    logic [MASK_W-1:0]  link_mask;
    err_code_t          err;
    logic               last;
  } result_t;

  // up to two results per word; slot 1 is used only together with slot 0
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

@@ rtl/core/event_fragment_parser_unit.sv @@
// ----------------------------------------------------------------------------
// event_fragment_parser_unit
// Parses event words into fragment records, error records and event summaries.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in_     | request   | in_valid / in_ready  | data_word, event_length, sof
//  out_    | result    | out_valid / out_ready| kind, fragment fields, summary
//
//  Flow: one event word per cycle while the queue has room; a taken word waits in
//  the input register, then goes to the output queue. A status word on the last word
//  of an event yields a fragment and a summary, unless it errors; both leave in order.
//  Throughput: the input register advances while the queue (depth 4) has two free slots.
//  Reset: rst_n synchronous, active low; clears parse state and queue.
//  Stalls: out_ready low fills the queue, then in_ready drops.
// ----------------------------------------------------------------------------
module event_fragment_parser_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_data_word,
  input  logic [15:0] in_event_length,
  input  logic        in_start_of_event,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_record_kind,
  output logic [4:0]  out_link_number,
  output logic [15:0] out_fragment_length,
  output logic [14:0] out_fragment_start,
  output logic [15:0] out_fragment_status,
  output logic [15:0] out_event_number,
  output logic [15:0] out_event_status,
  output logic [23:0] out_link_mask,
  output logic [1:0]  out_error_code,
  output logic        out_last_of_event
);

  // input register: holds one request until the parser takes it
  efp_pkg::item_t   item_r;
  logic             item_valid_r;
  logic             advance;
  logic             room2;
  efp_pkg::push_t   push;
  efp_pkg::result_t head;

  assign advance  = item_valid_r && room2;
  assign in_ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.data_word      <= in_data_word;
      item_r.event_length   <= in_event_length;
      item_r.start_of_event <= in_start_of_event;
    end
  end

  // decode and parse state
  efp_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .push    (push)
  );

  // result queue; output side reads its head
  efp_result_fifo u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (advance),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_record_kind     = head.kind;
  assign out_link_number     = head.link;
  assign out_fragment_length = head.frag_length;
  assign out_fragment_start  = head.frag_start;
  assign out_fragment_status = head.frag_status;
  assign out_event_number    = head.event_number;
  assign out_event_status    = head.event_status;
  assign out_link_mask       = head.link_mask;
  assign out_error_code      = head.err;
  assign out_last_of_event   = head.last;

endmodule

@@ rtl/core/efp_parse_core.sv @@
// ----------------------------------------------------------------------------
// efp_parse_core
// Per-word parse state and decode; emits fragment, summary and error results.
// ----------------------------------------------------------------------------
module efp_parse_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  efp_pkg::item_t item,
  output efp_pkg::push_t push
);

  logic [efp_pkg::POS_W-1:0]        word_position_r, word_position_nxt;
  logic [efp_pkg::POS_W-1:0]        next_len_pos_r, next_len_pos_nxt;
  logic [efp_pkg::STATUS_POS_W-1:0] pend_stat_pos_r, pend_stat_pos_nxt;
  logic [efp_pkg::POS_W-1:0]        pend_start_r, pend_start_nxt;
  logic [efp_pkg::WORD_W-1:0]       pend_length_r, pend_length_nxt;
  logic [efp_pkg::MASK_W-1:0]       seen_links_r, seen_links_nxt;
  logic [efp_pkg::WORD_W-1:0]       event_number_r, event_number_nxt;
  logic                             parse_active_r, parse_active_nxt;
  logic                             frag_open_r, frag_open_nxt;
  logic                             proceed;
  logic                             error_hit;

  always_comb begin
    logic [efp_pkg::POS_W-1:0]        elen;
    logic [efp_pkg::POS_W-1:0]        pos;
    logic [efp_pkg::STATUS_POS_W-1:0] sp;
    logic                             take;
    logic [efp_pkg::POS_W-1:0]        t_start;
    logic [efp_pkg::WORD_W-1:0]       t_len;
    logic [efp_pkg::LINK_W-1:0]       lnk;
    logic [efp_pkg::MASK_W-1:0]       bit_sel;
    logic                             summary;
    efp_pkg::err_code_t               err;
    efp_pkg::result_t                 rec;
    efp_pkg::result_t                 sum;

    word_position_nxt = word_position_r;
    next_len_pos_nxt  = next_len_pos_r;
    pend_stat_pos_nxt = pend_stat_pos_r;
    pend_start_nxt    = pend_start_r;
    pend_length_nxt   = pend_length_r;
    seen_links_nxt    = seen_links_r;
    event_number_nxt  = event_number_r;
    parse_active_nxt  = parse_active_r;
    frag_open_nxt     = frag_open_r;

    elen = item.event_length;
    if (elen > efp_pkg::MAX_EVENT_WORDS) begin
      elen = efp_pkg::MAX_EVENT_WORDS;
    end
    if (elen == '0) begin
      elen = efp_pkg::POS_W'(1);
    end

    proceed = item.start_of_event || parse_active_r;

    if (item.start_of_event) begin
      pos               = '0;
      event_number_nxt  = item.data_word;
      seen_links_nxt    = '0;
      parse_active_nxt  = 1'b1;
      frag_open_nxt     = 1'b0;
      next_len_pos_nxt  = efp_pkg::POS_W'(1);
      pend_stat_pos_nxt = '0;
      pend_start_nxt    = '0;
      pend_length_nxt   = '0;
    end else begin
      pos = word_position_r;
    end

    take    = 1'b0;
    t_start = '0;
    t_len   = '0;
    sp      = {1'b0, pos} + {1'b0, item.data_word};
    if (pos != '0) begin
      if (!frag_open_nxt && pos == next_len_pos_nxt) begin
        if (sp >= {1'b0, elen}) begin
          next_len_pos_nxt = '0;
        end else if (item.data_word == '0) begin
          // zero-length fragment: length word doubles as status
          take             = 1'b1;
          t_start          = pos;
          next_len_pos_nxt = pos + efp_pkg::POS_W'(1);
        end else begin
          frag_open_nxt     = 1'b1;
          pend_stat_pos_nxt = sp;
          pend_start_nxt    = pos;
          pend_length_nxt   = item.data_word;
        end
      end else if (frag_open_nxt && {1'b0, pos} == pend_stat_pos_nxt) begin
        frag_open_nxt    = 1'b0;
        take             = 1'b1;
        t_start          = pend_start_nxt;
        t_len            = pend_length_nxt;
        next_len_pos_nxt = pos + efp_pkg::POS_W'(1);
      end
    end

    lnk       = item.data_word[efp_pkg::LINK_W-1:0];
    bit_sel   = efp_pkg::MASK_W'(1) << lnk;
    err       = efp_pkg::ERR_NONE;
    error_hit = 1'b0;
    if (take) begin
      if (lnk > efp_pkg::LAST_LINK) begin
        err       = efp_pkg::ERR_LINK_RANGE;
        error_hit = 1'b1;
      end else if ((seen_links_nxt & bit_sel) != '0) begin
        err       = efp_pkg::ERR_LINK_REPEAT;
        error_hit = 1'b1;
      end else begin
        seen_links_nxt = seen_links_nxt | bit_sel;
      end
    end

    summary = (pos >= elen - efp_pkg::POS_W'(1)) && !error_hit;

    rec.kind         = error_hit ? efp_pkg::REC_ERROR : efp_pkg::REC_FRAGMENT;
    rec.link         = lnk;
    rec.frag_length  = t_len;
    rec.frag_start   = t_start[efp_pkg::START_W-1:0];
    rec.frag_status  = item.data_word;
    rec.event_number = event_number_nxt;
    rec.event_status = '0;
    rec.link_mask    = seen_links_nxt;
    rec.err          = err;
    rec.last         = error_hit;

    sum.kind         = efp_pkg::REC_SUMMARY;
    sum.link         = '0;
    sum.frag_length  = '0;
    sum.frag_start   = '0;
    sum.frag_status  = '0;
    sum.event_number = event_number_nxt;
    sum.event_status = item.data_word;
    sum.link_mask    = seen_links_nxt;
    sum.err          = efp_pkg::ERR_NONE;
    sum.last         = 1'b1;

    if (error_hit || summary) begin
      parse_active_nxt = 1'b0;
    end
    if (summary) begin
      frag_open_nxt = 1'b0;
    end
    word_position_nxt = pos + efp_pkg::POS_W'(1);

    push.v0 = proceed && (take || summary);
    push.r0 = take ? rec : sum;
    push.v1 = proceed && take && summary;
    push.r1 = sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_position_r <= '0;
      next_len_pos_r  <= efp_pkg::POS_W'(1);
      pend_stat_pos_r <= '0;
      pend_start_r    <= '0;
      pend_length_r   <= '0;
      seen_links_r    <= '0;
      event_number_r  <= '0;
      parse_active_r  <= 1'b0;
      frag_open_r     <= 1'b0;
    end else if (step_en && proceed) begin
      word_position_r <= word_position_nxt;
      next_len_pos_r  <= next_len_pos_nxt;
      pend_stat_pos_r <= pend_stat_pos_nxt;
      pend_start_r    <= pend_start_nxt;
      pend_length_r   <= pend_length_nxt;
      seen_links_r    <= seen_links_nxt;
      event_number_r  <= event_number_nxt;
      parse_active_r  <= parse_active_nxt;
      frag_open_r     <= frag_open_nxt;
    end
  end

  // an error ends the event: no summary follows it
  a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (push.v0 && push.r0.kind == efp_pkg::REC_ERROR) |-> !push.v1)
    else $error("error result paired with a second result");

  // after a taken error or summary the parser stops
  a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && push.v0 && (push.v1 || push.r0.last)) |=> !parse_active_r)
    else $error("parser still active after final result");

endmodule

@@ rtl/core/efp_result_fifo.sv @@
// ----------------------------------------------------------------------------
// efp_result_fifo
// Small result queue: up to two writes per cycle, one read.
// ----------------------------------------------------------------------------
module efp_result_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_en,
  input  efp_pkg::push_t   push,
  output logic             room2,
  output logic             out_valid,
  input  logic             out_ready,
  output efp_pkg::result_t head
);

  efp_pkg::result_t              mem_r [efp_pkg::RESQ_DEPTH];
  logic [efp_pkg::RESQ_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [efp_pkg::RESQ_CW-1:0]   count_r;
  logic [efp_pkg::RESQ_AW-1:0]   wr_ptr1;
  logic                          wr0, wr1, pop;
  logic [efp_pkg::RESQ_CW-1:0]   n_push;

  assign wr0     = push_en && push.v0;
  assign wr1     = push_en && push.v1;
  assign pop     = out_valid && out_ready;
  assign wr_ptr1 = wr_ptr_r + efp_pkg::RESQ_AW'(1);
  assign n_push  = efp_pkg::RESQ_CW'(wr0) + efp_pkg::RESQ_CW'(wr1);

  assign out_valid = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign room2     = (count_r <= efp_pkg::RESQ_CW'(efp_pkg::RESQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (wr0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (wr1) begin
      mem_r[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + efp_pkg::RESQ_AW'(n_push);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + efp_pkg::RESQ_AW'(1);
      end
      count_r <= count_r + n_push - efp_pkg::RESQ_CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= efp_pkg::RESQ_CW'(efp_pkg::RESQ_DEPTH))
    else $error("result queue overflow");

  a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
    (wr0 || wr1) |-> room2)
    else $error("push without two free slots");

  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    wr1 |-> wr0)
    else $error("second slot written without first");

endmodule
